[sv/gsp_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gsp_pkg
// shared word types and constants for the grid source placement search
// ---------------------------------------------------------------------------
package gsp_pkg;

  localparam int unsigned TimeW = 13;
  localparam int unsigned TimeMax = 4095;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_WALL = 2'd1;
  localparam logic [1:0] KIND_SOURCE = 2'd2;

  localparam logic REG_GRID_SIDE = 1'b0;
  localparam logic REG_PICK_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0] cell_kind;
    logic       last_cell;
  } in_word_t;

  typedef struct packed {
    logic signed [TimeW-1:0] least_time;
    logic                    found;
  } out_word_t;

  // per-row control from the sequencer
  typedef struct packed {
    logic load_seed;
    logic expand;
    logic wall_we;
    logic wall_bit;
  } gsp_ctrl_t;

endpackage
`default_nettype wire

[sv/gsp_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gsp_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module gsp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/gsp_row_cell.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gsp_row_cell
// one grid row: wall bits and reached bits, grows from its row neighbors
// ---------------------------------------------------------------------------
module gsp_row_cell #(
  parameter int MAX_SIDE = 64
) (
  input  wire logic                        clk,
  input  wire gsp_pkg::gsp_ctrl_t          ctrl,
  input  wire logic [$clog2(MAX_SIDE)-1:0] wall_col,
  input  wire logic [MAX_SIDE-1:0]         active,
  input  wire logic [MAX_SIDE-1:0]         seed,
  input  wire logic [MAX_SIDE-1:0]         up,
  input  wire logic [MAX_SIDE-1:0]         down,
  output logic      [MAX_SIDE-1:0]         reached,
  output logic                             changed,
  output logic                             hole
);
  import gsp_pkg::*;

  logic [MAX_SIDE-1:0] wall;
  logic [MAX_SIDE-1:0] reached_next;

  always_comb begin
    reached_next = (reached | (reached << 1) | (reached >> 1) | up | down)
                   & ~wall & active;
    changed = ctrl.expand && (reached_next != reached);
    hole = |(active & ~wall & ~reached);
  end

  always_ff @(posedge clk) begin
    if (ctrl.wall_we) begin
      wall[wall_col] <= ctrl.wall_bit;
    end
    if (ctrl.load_seed) begin
      reached <= seed;
    end else if (ctrl.expand) begin
      reached <= reached_next;
    end
  end
endmodule
`default_nettype wire

[sv/grid_source_placement_bfs.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// grid_source_placement_bfs
// loads a grid, tries every pick_count subset of sources, reports best fill time
// ---------------------------------------------------------------------------
// load: one cell word per cycle; the last cell word starts the search
// search: the flat grid of side*side cells is moved into the row chain,
//   then the subset masks (2^candidates masks) are scanned in turn,
//   and each tried subset is seeded, then grows one wavefront step a cycle
// the answer word is registered in the finish state once the answer register is free; input stalls meanwhile
// rst (synchronous) clears control; the cell ram holds no reset
module grid_source_placement_bfs #(
  parameter int MAX_SIDE = 64,
  parameter int MAX_CANDIDATES = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire gsp_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output gsp_pkg::out_word_t      out_word,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);
  import gsp_pkg::*;

  localparam int SW = $clog2(MAX_SIDE + 1);          // side value width
  localparam int CW = $clog2(MAX_SIDE);              // row / column index width
  localparam int PW = $clog2(MAX_SIDE * MAX_SIDE);   // flat position width
  localparam int NW = PW + 1;                        // cell count width
  localparam int KW = $clog2(MAX_CANDIDATES + 1);    // candidate count width
  localparam int MW = MAX_CANDIDATES + 1;            // subset mask width

  typedef enum logic [2:0] {
    S_LOAD, S_SWEEP, S_SEEK, S_INIT, S_EXPAND, S_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [6:0] grid_side;
  logic [3:0] pick_count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PICK_COUNT) ? {28'd0, pick_count} : {25'd0, grid_side};

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= 7'd8;
      pick_count <= 4'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_GRID_SIDE) begin
        grid_side <= pwdata[6:0];
      end else begin
        pick_count <= pwdata[3:0];
      end
    end
  end

  // side in use: zero acts as one, large values clamp to the array size
  logic [SW-1:0] side_use;
  logic [NW-1:0] cell_count;

  always_comb begin
    if (grid_side == 7'd0) begin
      side_use = SW'(1);
    end else if (32'(grid_side) > 32'(MAX_SIDE)) begin
      side_use = SW'(MAX_SIDE);
    end else begin
      side_use = SW'(grid_side);
    end
    cell_count = NW'(side_use) * NW'(side_use);
  end

  // load side
  logic [NW-1:0] load_pos;
  logic [KW-1:0] cand_total;
  logic [PW-1:0] cand_pos [MAX_CANDIDATES];
  logic          in_take;
  logic          load_in_grid;

  assign in_stall = (state != S_LOAD);
  assign in_take = in_valid && !in_stall;
  assign load_in_grid = load_pos < cell_count;

  // sweep of the flat wall store into the row chain
  logic [NW-1:0] sweep_q;
  logic [CW-1:0] sweep_row, sweep_col;
  logic          pipe_vld;
  logic [NW-1:0] pipe_q;
  logic [CW-1:0] pipe_row, pipe_col;
  logic          wall_rd;
  logic          sweep_issue;

  assign sweep_issue = (state == S_SWEEP) && (sweep_q < cell_count);

  gsp_ram #(.WIDTH(1), .DEPTH(MAX_SIDE * MAX_SIDE)) u_wall_ram (
    .clk   (clk),
    .we    (in_take && load_in_grid),
    .waddr (load_pos[PW-1:0]),
    .wdata (in_word.cell_kind == KIND_WALL),
    .raddr (sweep_q[PW-1:0]),
    .rdata (wall_rd)
  );

  // candidates converted to row and column under the side in use
  logic [CW-1:0]             cand_row [MAX_CANDIDATES];
  logic [CW-1:0]             cand_col [MAX_CANDIDATES];
  logic [MAX_CANDIDATES-1:0] cand_ok;

  // subset search
  logic [MW-1:0]  mask;
  logic [MW-1:0]  mask_hold;
  logic [NW-1:0]  wave_step;
  logic [NW-1:0]  best;
  logic           best_valid;
  logic           any_src;
  logic [KW:0]    mask_bits;
  logic [MW-1:0]  mask_limit;

  always_comb begin
    mask_bits = '0;
    for (int c = 0; c < MAX_CANDIDATES; c++) begin
      mask_bits = mask_bits + (KW + 1)'(mask[c]);
    end
    mask_limit = MW'(1) << cand_total;
  end

  // row chain
  logic [MAX_SIDE-1:0] reached_row [MAX_SIDE];
  logic [MAX_SIDE-1:0] changed_row;
  logic [MAX_SIDE-1:0] hole_row;
  logic [MAX_SIDE-1:0] col_mask;

  always_comb begin
    for (int x = 0; x < MAX_SIDE; x++) begin
      col_mask[x] = SW'(x) < side_use;
    end
  end

  for (genvar r = 0; r < MAX_SIDE; r++) begin : g_row
    gsp_ctrl_t           ctrl;
    logic [MAX_SIDE-1:0] seed;
    logic [MAX_SIDE-1:0] act;
    logic [MAX_SIDE-1:0] up_in;
    logic [MAX_SIDE-1:0] down_in;

    always_comb begin
      ctrl.load_seed = (state == S_INIT);
      ctrl.expand = (state == S_EXPAND);
      ctrl.wall_we = pipe_vld && (pipe_row == CW'(r));
      ctrl.wall_bit = wall_rd;
      act = (SW'(r) < side_use) ? col_mask : '0;
      seed = '0;
      for (int c = 0; c < MAX_CANDIDATES; c++) begin
        if (mask_hold[c] && cand_ok[c] && cand_row[c] == CW'(r)) begin
          seed[cand_col[c]] = 1'b1;
        end
      end
    end

    if (r == 0) begin : g_top
      assign up_in = '0;
    end else begin : g_mid_up
      assign up_in = reached_row[r-1];
    end
    if (r == MAX_SIDE - 1) begin : g_bottom
      assign down_in = '0;
    end else begin : g_mid_down
      assign down_in = reached_row[r+1];
    end

    gsp_row_cell #(.MAX_SIDE(MAX_SIDE)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .wall_col (pipe_col),
      .active   (act),
      .seed     (seed),
      .up       (up_in),
      .down     (down_in),
      .reached  (reached_row[r]),
      .changed  (changed_row[r]),
      .hole     (hole_row[r])
    );
  end

  // saturated answer
  logic [TimeW-1:0] time_sat;
  assign time_sat = (32'(best) > TimeMax) ? TimeW'(TimeMax) : TimeW'(best);

  // answer register takes a new word when empty or draining this cycle
  logic out_load;
  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      load_pos <= '0;
      cand_total <= '0;
      best_valid <= 1'b0;
      out_valid <= 1'b0;
      pipe_vld <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      pipe_vld <= sweep_issue;
      case (state)
        S_LOAD: begin
          if (in_take) begin
            if (load_in_grid) begin
              load_pos <= load_pos + NW'(1);
              if (in_word.cell_kind == KIND_SOURCE &&
                  32'(cand_total) < MAX_CANDIDATES) begin
                cand_pos[cand_total] <= load_pos[PW-1:0];
                cand_total <= cand_total + KW'(1);
              end
            end
            if (in_word.last_cell) begin
              state <= S_SWEEP;
              sweep_q <= '0;
              sweep_row <= '0;
              sweep_col <= '0;
              cand_ok <= '0;
            end
          end
        end
        S_SWEEP: begin
          if (sweep_issue) begin
            sweep_q <= sweep_q + NW'(1);
            if (SW'(sweep_col) + SW'(1) == side_use) begin
              sweep_col <= '0;
              sweep_row <= sweep_row + CW'(1);
            end else begin
              sweep_col <= sweep_col + CW'(1);
            end
          end else if (!pipe_vld) begin
            state <= S_SEEK;
            mask <= '0;
          end
          if (pipe_vld) begin
            for (int c = 0; c < MAX_CANDIDATES; c++) begin
              if (32'(c) < 32'(cand_total) && NW'(cand_pos[c]) == pipe_q) begin
                cand_row[c] <= pipe_row;
                cand_col[c] <= pipe_col;
                cand_ok[c] <= 1'b1;
              end
            end
          end
        end
        S_SEEK: begin
          if (pick_count == 4'd0 || mask == mask_limit) begin
            state <= S_FINISH;
          end else begin
            if (32'(mask_bits) == 32'(pick_count)) begin
              state <= S_INIT;
            end
            mask <= mask + MW'(1);
          end
        end
        S_INIT: begin
          // mask already advanced; seeding reads the held copy of the tested subset
          state <= S_EXPAND;
          wave_step <= '0;
        end
        S_EXPAND: begin
          if (|changed_row) begin
            wave_step <= wave_step + NW'(1);
          end else begin
            if (any_src && !(|hole_row)) begin
              if (!best_valid || wave_step < best) begin
                best <= wave_step;
              end
              best_valid <= 1'b1;
            end
            state <= S_SEEK;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            out_word.found <= best_valid;
            out_word.least_time <= best_valid ? $signed(time_sat) : -13'sd1;
            load_pos <= '0;
            cand_total <= '0;
            best_valid <= 1'b0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // seeding must see the subset that was tested, so hold a copy
  always_ff @(posedge clk) begin
    if (state == S_SEEK) begin
      mask_hold <= mask;
    end
    if (state == S_INIT) begin
      any_src <= |(mask_hold[MAX_CANDIDATES-1:0] & cand_ok);
    end
    pipe_q <= sweep_q;
    pipe_row <= sweep_row;
    pipe_col <= sweep_col;
  end

endmodule
`default_nettype wire
